// ===== rtl/core/tcsm_pkg.sv =====
// Shared constants, types and the cosine table builder of the three channel solo mixer.
`timescale 1ns / 1ps
package tcsm_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CLIP_DEPTH_DEF  = 256;

    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam int          ALPHA_W     = 23;
    localparam logic [ALPHA_W-1:0] ALPHA_Q32 = 23'd4294967;

    typedef enum logic [1:0] {
        REG_RED_GAIN,
        REG_GREEN_GAIN,
        REG_BLUE_GAIN,
        REG_MIX_GAIN
    } tcsm_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAIN,
        ST_GROUND,
        ST_CWAIT,
        ST_LTGT,
        ST_LADD,
        ST_LMUL,
        ST_LUPD,
        ST_SUM,
        ST_MMUL,
        ST_MRND,
        ST_MWAIT,
        ST_OUT
    } tcsm_state_t;

    typedef struct packed {
        logic [2:0] pass;
        logic [5:0] solo;
        logic       bank;
    } tcsm_ctl_t;

    // Quarter-wave cosine in Q15 from a Q30 Horner series to x^12.
    function automatic logic [15:0] cos_q15(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] e;
        x2 = (x * x) >> 30;
        r  = ONE_Q30;
        t  = ((x2 * r) >> 30) / 64'd132;
        r  = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
        t  = ((x2 * r) >> 30) / 64'd90;
        r  = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
        t  = ((x2 * r) >> 30) / 64'd56;
        r  = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
        t  = ((x2 * r) >> 30) / 64'd30;
        r  = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
        t  = ((x2 * r) >> 30) / 64'd12;
        r  = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
        t  = ((x2 * r) >> 30) / 64'd2;
        r  = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
        e  = (r + 64'd16384) >> 15;
        if (e > 64'd32768)
        begin
            e = 64'd32768;
        end
        return e[15:0];
    endfunction

endpackage

// ===== rtl/core/tcsm_if.sv =====
// Handshake interfaces for the input, result and register write channels.
`timescale 1ns / 1ps
interface tcsm_in_if
    import tcsm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] red_sample;
    logic signed [SAMPLE_BITS-1:0] green_sample;
    logic signed [SAMPLE_BITS-1:0] blue_sample;
    logic [2:0]                    connected_mask;
    logic [3:0]                    button_levels;

    modport source (output valid, red_sample, green_sample, blue_sample, connected_mask,
                    button_levels, input ready);
    modport sink (input valid, red_sample, green_sample, blue_sample, connected_mask,
                  button_levels, output ready);
endinterface

interface tcsm_out_if
    import tcsm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] red_out;
    logic signed [SAMPLE_BITS-1:0] green_out;
    logic signed [SAMPLE_BITS-1:0] blue_out;
    logic signed [SAMPLE_BITS-1:0] bipolar_mix;
    logic signed [SAMPLE_BITS-1:0] unipolar_mix;
    logic [15:0]                   red_led;
    logic [15:0]                   green_led;
    logic [15:0]                   blue_led;
    logic [2:0]                    mix_pass_mask;
    logic [5:0]                    solo_state;
    logic                          bank_out;

    modport source (output valid, red_out, green_out, blue_out, bipolar_mix, unipolar_mix,
                    red_led, green_led, blue_led, mix_pass_mask, solo_state, bank_out,
                    input ready);
    modport sink (input valid, red_out, green_out, blue_out, bipolar_mix, unipolar_mix,
                  red_led, green_led, blue_led, mix_pass_mask, solo_state, bank_out,
                  output ready);
endinterface

interface tcsm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tcsm_front.sv =====
// Front end: input selection for unconnected jacks and solo/bank button handling.
`timescale 1ns / 1ps
module tcsm_front
    import tcsm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    tcsm_in_if.sink                   in_ch,
    output logic                      push_valid,
    input  logic                      push_ready,
    output logic [3*SAMPLE_BITS-1:0]  push_chans,
    output tcsm_ctl_t                 push_ctl
);

    localparam logic signed [SAMPLE_BITS-1:0] V5 = SAMPLE_BITS'(5 << (SAMPLE_BITS - 5));

    logic [5:0] solo_reg;
    logic [5:0] solo_next;
    logic       bank_reg;
    logic       bank_next;
    logic [3:0] prev_reg;
    logic [3:0] edges;
    logic [2:0] active;
    logic signed [SAMPLE_BITS-1:0] ch0;
    logic signed [SAMPLE_BITS-1:0] ch1;
    logic signed [SAMPLE_BITS-1:0] ch2;

    assign push_valid  = in_ch.valid;
    assign in_ch.ready = push_ready;

    // Unconnected red is 5 V; green and blue copy the channel before them.
    assign ch0 = in_ch.connected_mask[0] ? in_ch.red_sample : V5;
    assign ch1 = in_ch.connected_mask[1] ? in_ch.green_sample : ch0;
    assign ch2 = in_ch.connected_mask[2] ? in_ch.blue_sample : ch1;
    assign push_chans = {ch2, ch1, ch0};

    // Channel edges toggle the bank selected before this item's bank edge.
    assign edges     = in_ch.button_levels & ~prev_reg;
    assign solo_next = solo_reg ^ (bank_reg ? {edges[2:0], 3'b000} : {3'b000, edges[2:0]});
    assign bank_next = bank_reg ^ edges[3];
    assign active    = bank_next ? solo_next[5:3] : solo_next[2:0];

    assign push_ctl.pass = (active != 3'b000) ? active : 3'b111;
    assign push_ctl.solo = solo_next;
    assign push_ctl.bank = bank_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            solo_reg <= '0;
            bank_reg <= 1'b0;
            prev_reg <= '0;
        end
        else if (in_ch.valid && push_ready)
        begin
            solo_reg <= solo_next;
            bank_reg <= bank_next;
            prev_reg <= in_ch.button_levels;
        end
    end

endmodule

// ===== rtl/core/tcsm_fifo.sv =====
// Two-entry item queue between the front end and the processing sequencer.
`timescale 1ns / 1ps
module tcsm_fifo
    import tcsm_pkg::*;
#(
    parameter int WIDTH = 3 * SAMPLE_BITS_DEF + $bits(tcsm_ctl_t)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/tcsm_clip.sv =====
// Four-stage cosine soft clip of a magnitude at a 5 V or 10 V threshold.
`timescale 1ns / 1ps
module tcsm_clip
    import tcsm_pkg::*;
#(
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int CLIP_TABLE_DEPTH = CLIP_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   sel_mix,
    input  logic [SAMPLE_BITS-1:0] mag,
    output logic                   done,
    output logic [SAMPLE_BITS-1:0] res
);

    localparam int SB = SAMPLE_BITS;
    localparam int D  = CLIP_TABLE_DEPTH;
    localparam int DW = $clog2(D + 1);
    localparam int NW = SB + DW + 1;
    localparam int MW = DW + 6;
    localparam int K  = MW + 3;
    localparam int PW = MW + K;
    localparam logic [K-1:0]  RECIP5 = K'(((1 << K) + 4) / 5);
    localparam logic [SB-1:0] T5     = SB'(5 << (SB - 5));
    localparam logic [SB-1:0] T10    = SB'(10 << (SB - 5));
    localparam logic [MW-1:0] F4     = MW'(4 * D);
    localparam logic [MW-1:0] F1     = MW'(D);
    localparam logic [MW-1:0] F2     = MW'(2 * D);
    localparam logic [MW-1:0] F3     = MW'(3 * D);

    logic [15:0] cos_rom [0:D];

    for (genvar k = 0; k <= D; k++)
    begin : g_rom
        localparam logic [63:0] XK = 64'(k) * PI_HALF_Q30 / 64'(CLIP_TABLE_DEPTH);
        assign cos_rom[k] = cos_q15(XK);
    end

    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic          sel_reg;
    logic          ge_reg;
    logic [SB-1:0] mag_reg;
    logic [NW-1:0] n_reg;
    logic [PW-1:0] prod_reg;
    logic [16:0]   c_reg;
    logic [SB-1:0] res_reg;

    logic [SB-1:0] t_in;
    logic [SB-1:0] t_cur;
    logic [MW-1:0] m_val;
    logic [MW-1:0] q0, q1, q2;
    logic [DW-1:0] idx;
    logic          cneg;
    logic [15:0]   cosv;
    logic [SB+17:0] oprod;

    assign t_in  = sel_mix ? T10 : T5;
    assign t_cur = sel_reg ? T10 : T5;

    // Dividing by T is a shift by its power of two, then a division by five.
    assign m_val = sel_reg ? MW'(n_reg >> (SB - 4)) : MW'(n_reg >> (SB - 5));

    assign q0 = MW'(prod_reg >> K);
    assign q1 = (q0 >= F4) ? q0 - F4 : q0;
    assign q2 = (q1 >= F4) ? q1 - F4 : q1;

    // Fold the full period onto the quarter-wave table.
    always_comb
    begin
        priority if (q2 <= F1)
        begin
            idx  = DW'(q2);
            cneg = 1'b0;
        end
        else if (q2 <= F2)
        begin
            idx  = DW'(F2 - q2);
            cneg = 1'b1;
        end
        else if (q2 <= F3)
        begin
            idx  = DW'(q2 - F2);
            cneg = 1'b1;
        end
        else
        begin
            idx  = DW'(F4 - q2);
            cneg = 1'b0;
        end
    end

    assign cosv  = cos_rom[idx];
    assign oprod = (SB + 18)'(t_cur) * (SB + 18)'(c_reg) + (SB + 18)'(32768);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sel_reg <= sel_mix;
            ge_reg  <= (mag >= t_in);
            mag_reg <= mag;
            n_reg   <= NW'(mag - t_in) * NW'(D) + NW'(t_in >> 1);
        end
        if (v1_reg)
        begin
            prod_reg <= PW'(m_val) * PW'(RECIP5);
        end
        if (v2_reg)
        begin
            c_reg <= cneg ? 17'd32768 - 17'(cosv) : 17'd32768 + 17'(cosv);
        end
        if (v3_reg)
        begin
            // The curve never exceeds T, so the 10 V clamp is already met.
            res_reg <= ge_reg ? SB'(oprod >> 16) : mag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign done = v4_reg;
    assign res  = res_reg;

endmodule

// ===== rtl/core/tcsm_back.sv =====
// Processing sequencer: gains, soft clip, LED smoothing, muting and the two mixes.
`timescale 1ns / 1ps
module tcsm_back
    import tcsm_pkg::*;
#(
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int CLIP_TABLE_DEPTH = CLIP_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    tcsm_cfg_if.sink                 cfg,
    input  logic                     pop_valid,
    output logic                     pop_ready,
    input  logic [3*SAMPLE_BITS-1:0] pop_chans,
    input  tcsm_ctl_t                pop_ctl,
    tcsm_out_if.source               out_ch
);

    localparam int SB  = SAMPLE_BITS;
    localparam int E   = 37 - SB;
    localparam int C1W = E - 1;
    localparam logic [C1W-1:0] C1 = C1W'((1 << E) / 5);
    localparam logic [2:0]     EREM = 3'((1 << E) % 5);
    localparam int K5  = SB + 5;
    localparam logic [K5-1:0]  R5 = K5'(((1 << K5) + 4) / 5);
    localparam logic [SB-1:0]  V5 = SB'(5 << (SB - 5));

    tcsm_state_t state_reg;
    tcsm_state_t state_next;

    logic [14:0]          gain_reg [3];
    logic signed [15:0]   mixg_reg;
    logic signed [SB-1:0] chraw_reg [3];
    tcsm_ctl_t            ctl_reg;
    logic [1:0]           idx_reg;
    logic [SB+14:0]       gprod_reg;
    logic                 neg_reg;
    logic signed [SB-1:0] chan_reg [3];
    logic [SB-1:0]        fmag_reg;
    logic [SB+C1W-1:0]    lda_reg;
    logic [SB-1:0]        ldb_reg;
    logic                 atmax_reg;
    logic [31:0]          target_reg;
    logic [31+ALPHA_W:0]  pm_reg;
    logic                 dneg_reg;
    logic [31:0]          level_reg [3];
    logic signed [SB:0]   sum_reg;
    logic [SB+15:0]       mprod_reg;
    logic                 bneg_reg;
    logic                 uneg_reg;
    logic signed [SB-1:0] bip_reg;
    logic signed [SB-1:0] uni_reg;
    logic                 outv_reg;

    logic                 clip_start;
    logic                 clip_sel;
    logic [SB-1:0]        clip_mag;
    logic                 clip_done;
    logic [SB-1:0]        clip_res;
    logic                 out_load;

    logic signed [SB-1:0] v_cur;
    logic [SB-1:0]        vmag;
    logic [SB+2:0]        bx;
    logic [2*SB+7:0]      bprod;
    logic signed [32:0]   dval;
    logic [31:0]          dabs;
    logic [23:0]          adj;
    logic signed [33:0]   nval;
    logic signed [SB:0]   msum;
    logic [SB-1:0]        smag;
    logic [15:0]          mgabs;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg[0] <= '0;
            gain_reg[1] <= '0;
            gain_reg[2] <= '0;
            mixg_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (tcsm_reg_t'(cfg.index))
                REG_RED_GAIN:   gain_reg[0] <= cfg.data[14:0];
                REG_GREEN_GAIN: gain_reg[1] <= cfg.data[14:0];
                REG_BLUE_GAIN:  gain_reg[2] <= cfg.data[14:0];
                REG_MIX_GAIN:   mixg_reg    <= cfg.data;
                default:        mixg_reg    <= mixg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop_ready  = 1'b0;
        clip_start = 1'b0;
        clip_sel   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:   state_next = ST_GROUND;
            ST_GROUND:
            begin
                clip_start = 1'b1;
                state_next = ST_CWAIT;
            end
            ST_CWAIT:
            begin
                if (clip_done)
                begin
                    state_next = ST_LTGT;
                end
            end
            ST_LTGT:   state_next = ST_LADD;
            ST_LADD:   state_next = ST_LMUL;
            ST_LMUL:   state_next = ST_LUPD;
            ST_LUPD:   state_next = (idx_reg == 2'd2) ? ST_SUM : ST_GAIN;
            ST_SUM:    state_next = ST_MMUL;
            ST_MMUL:   state_next = ST_MRND;
            ST_MRND:
            begin
                clip_start = 1'b1;
                clip_sel   = 1'b1;
                state_next = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                clip_sel = 1'b1;
                if (clip_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!outv_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Round half away from zero on the Q14 product magnitude.
    assign clip_mag = (state_reg == ST_MRND)
                    ? SB'(({1'b0, mprod_reg} + (SB + 17)'(8192)) >> 14)
                    : SB'(({1'b0, gprod_reg} + (SB + 16)'(8192)) >> 14);

    tcsm_clip #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .CLIP_TABLE_DEPTH (CLIP_TABLE_DEPTH)
    ) u_clip (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (clip_start),
        .sel_mix (clip_sel),
        .mag     (clip_mag),
        .done    (clip_done),
        .res     (clip_res)
    );

    assign v_cur = chraw_reg[idx_reg];
    assign vmag  = v_cur[SB-1] ? SB'(-v_cur) : SB'(v_cur);

    // Target is f * 2^E / 5, split into f * floor(2^E / 5) and a small remainder term.
    assign bx    = (SB + 3)'(fmag_reg) * (SB + 3)'(EREM);
    assign bprod = (2 * SB + 8)'(bx) * (2 * SB + 8)'(R5);

    assign dval = $signed({1'b0, target_reg}) - $signed({1'b0, level_reg[idx_reg]});
    assign dabs = dval[32] ? 32'(-dval) : 32'(dval);
    assign adj  = 24'(({1'b0, pm_reg} + (33 + ALPHA_W)'(64'h80000000)) >> 32);
    assign nval = dneg_reg ? $signed({2'b00, level_reg[idx_reg]}) - $signed({10'd0, adj})
                           : $signed({2'b00, level_reg[idx_reg]}) + $signed({10'd0, adj});

    assign msum = (ctl_reg.pass[0] ? (SB + 1)'(chan_reg[0]) : '0)
                + (ctl_reg.pass[1] ? (SB + 1)'(chan_reg[1]) : '0)
                + (ctl_reg.pass[2] ? (SB + 1)'(chan_reg[2]) : '0);
    assign smag  = sum_reg[SB] ? SB'(-sum_reg) : SB'(sum_reg);
    assign mgabs = mixg_reg[15] ? 16'(-mixg_reg) : 16'(mixg_reg);

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                chraw_reg[0] <= pop_chans[SB-1:0];
                chraw_reg[1] <= pop_chans[2*SB-1:SB];
                chraw_reg[2] <= pop_chans[3*SB-1:2*SB];
                ctl_reg      <= pop_ctl;
                idx_reg      <= 2'd0;
            end
            ST_GAIN:
            begin
                gprod_reg <= (SB + 15)'(vmag) * (SB + 15)'(gain_reg[idx_reg]);
                neg_reg   <= v_cur[SB-1];
            end
            ST_CWAIT:
            begin
                if (clip_done)
                begin
                    fmag_reg          <= clip_res;
                    chan_reg[idx_reg] <= neg_reg ? -$signed(clip_res) : $signed(clip_res);
                end
            end
            ST_LTGT:
            begin
                lda_reg   <= (SB + C1W)'(fmag_reg) * (SB + C1W)'(C1);
                ldb_reg   <= SB'(bprod >> K5);
                atmax_reg <= (fmag_reg >= V5);
            end
            ST_LADD:
            begin
                target_reg <= atmax_reg ? 32'hFFFF_FFFF : 32'(lda_reg + (SB + C1W)'(ldb_reg));
            end
            ST_LMUL:
            begin
                pm_reg   <= (32 + ALPHA_W)'(dabs) * (32 + ALPHA_W)'(ALPHA_Q32);
                dneg_reg <= dval[32];
            end
            ST_LUPD:
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            ST_SUM:
            begin
                sum_reg <= msum;
            end
            ST_MMUL:
            begin
                mprod_reg <= (SB + 16)'(smag) * (SB + 16)'(mgabs);
                bneg_reg  <= sum_reg[SB] ^ mixg_reg[15];
                uneg_reg  <= sum_reg[SB];
            end
            ST_MWAIT:
            begin
                if (clip_done)
                begin
                    bip_reg <= bneg_reg ? -$signed(clip_res) : $signed(clip_res);
                    uni_reg <= uneg_reg ? -$signed(clip_res) : $signed(clip_res);
                end
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg[0] <= '0;
            level_reg[1] <= '0;
            level_reg[2] <= '0;
        end
        else if (state_reg == ST_LUPD)
        begin
            level_reg[idx_reg] <= (nval < 0) ? 32'd0
                                : (nval > 34'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : nval[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outv_reg <= 1'b0;
        end
        else if (out_load)
        begin
            outv_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            outv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ch.red_out       <= ctl_reg.pass[0] ? chan_reg[0] : '0;
            out_ch.green_out     <= ctl_reg.pass[1] ? chan_reg[1] : '0;
            out_ch.blue_out      <= ctl_reg.pass[2] ? chan_reg[2] : '0;
            out_ch.bipolar_mix   <= bip_reg;
            out_ch.unipolar_mix  <= uni_reg;
            out_ch.red_led       <= level_reg[0][31:16];
            out_ch.green_led     <= level_reg[1][31:16];
            out_ch.blue_led      <= level_reg[2][31:16];
            out_ch.mix_pass_mask <= ctl_reg.pass;
            out_ch.solo_state    <= ctl_reg.solo;
            out_ch.bank_out      <= ctl_reg.bank;
        end
    end

    assign out_ch.valid = outv_reg;

endmodule

// ===== rtl/core/three_channel_solo_mixer_top.sv =====
// Top level of the three channel solo mixer.
`timescale 1ns / 1ps
// Each input item carries one sample per channel, the jack connection flags and
// the four button levels; each item yields exactly one result item. The front end
// resolves unconnected jacks and updates the solo flags and bank as the item is
// accepted, and queues it in a two-entry buffer. The back end works on one item at a
// time: per channel a gain multiply, a four-stage soft clip and an LED smoother
// step, then the muted sum and the mix multiply through the same shared clip unit.
// Loading the result register waits while the result before it is not yet taken.
// Gain registers may be written only while no item is in flight.
module three_channel_solo_mixer_top
    import tcsm_pkg::*;
#(
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int CLIP_TABLE_DEPTH = CLIP_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    tcsm_in_if.sink    in_ch,
    tcsm_out_if.source out_ch,
    tcsm_cfg_if.sink   cfg
);

    localparam int QW = 3 * SAMPLE_BITS + $bits(tcsm_ctl_t);

    logic                     push_valid;
    logic                     push_ready;
    logic [3*SAMPLE_BITS-1:0] push_chans;
    tcsm_ctl_t                push_ctl;
    logic                     pop_valid;
    logic                     pop_ready;
    logic [QW-1:0]            pop_data;
    tcsm_ctl_t                pop_ctl;

    tcsm_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_chans (push_chans),
        .push_ctl   (push_ctl)
    );

    tcsm_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  ({push_chans, push_ctl}),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    assign pop_ctl = pop_data[$bits(tcsm_ctl_t)-1:0];

    tcsm_back #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .CLIP_TABLE_DEPTH (CLIP_TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_chans (pop_data[QW-1:$bits(tcsm_ctl_t)]),
        .pop_ctl   (pop_ctl),
        .out_ch    (out_ch)
    );

endmodule

// ===== sim/tcsm_checker.sv =====
// Checker for the three channel solo mixer: predicts each result and compares it.
`timescale 1ns / 1ps
module tcsm_checker
    import tcsm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    tcsm_in_if     in_ch,
    tcsm_out_if    out_ch,
    tcsm_cfg_if    cfg,
    output int     fail_count,
    output int     pending_count
);

    localparam int DEPTH = 256;
    localparam longint VOLT = 2048;
    localparam longint V5 = 5 * VOLT;
    localparam longint V10 = 10 * VOLT;

    typedef struct {
        logic [15:0] ch_out [3];
        logic [15:0] bip;
        logic [15:0] uni;
        logic [15:0] led [3];
        logic [2:0]  pass;
        logic [5:0]  solo;
        logic        bank;
    } mix_result_t;

    longint      cos_lut [DEPTH+1];
    logic [14:0] ch_gain [3];
    logic [15:0] mix_gain;
    logic [5:0]  solo_flags;
    logic        bank_sel;
    logic [3:0]  prev_buttons;
    longint      led_acc [3];
    mix_result_t expected_results [$];

    assign pending_count = expected_results.size();

    // Quarter-wave cosine, Q15, built independently of the package function.
    initial
    begin
        longint unsigned x;
        longint unsigned x2;
        longint unsigned r;
        longint unsigned t;
        longint unsigned e;
        longint unsigned dens [6];
        dens = '{132, 90, 56, 30, 12, 2};
        for (int k = 0; k <= DEPTH; k++)
        begin
            x = longint'(k) * 64'd1686629713 / DEPTH;
            x2 = (x * x) >> 30;
            r = 64'd1 << 30;
            for (int i = 0; i < 6; i++)
            begin
                t = ((x2 * r) >> 30) / dens[i];
                r = (t > (64'd1 << 30)) ? 0 : (64'd1 << 30) - t;
            end
            e = (r + 16384) >> 15;
            if (e > 32768)
            begin
                e = 32768;
            end
            cos_lut[k] = longint'(e);
        end
    end

    function automatic longint scale_q14(longint v, longint g);
        longint mv;
        longint mg;
        longint r;
        mv = v < 0 ? -v : v;
        mg = g < 0 ? -g : g;
        r = (mv * mg + 8192) >>> 14;
        return ((v < 0) != (g < 0)) ? -r : r;
    endfunction

    function automatic longint cosine_at(longint q);
        q = q % (4 * DEPTH);
        if (q <= DEPTH)
        begin
            return cos_lut[q];
        end
        if (q <= 2 * DEPTH)
        begin
            return -cos_lut[2 * DEPTH - q];
        end
        if (q <= 3 * DEPTH)
        begin
            return -cos_lut[q - 2 * DEPTH];
        end
        return cos_lut[4 * DEPTH - q];
    endfunction

    function automatic longint soft_clip(longint v, longint thr);
        longint mag;
        longint p;
        longint q;
        longint o;
        longint r;
        mag = v < 0 ? -v : v;
        r = v;
        if (mag >= thr)
        begin
            p = mag - thr;
            q = (p * DEPTH + thr / 2) / thr;
            o = (thr * (32768 + cosine_at(q)) + 32768) >>> 16;
            r = (v >= 0) ? o : -o;
        end
        if (r > V10)
        begin
            r = V10;
        end
        if (r < -V10)
        begin
            r = -V10;
        end
        return r;
    endfunction

    function automatic longint smooth_led(longint level, longint v);
        longint mag;
        longint target;
        longint d;
        longint unsigned pm;
        longint adj;
        longint n;
        mag = v < 0 ? -v : v;
        target = (mag >= V5) ? 64'hFFFF_FFFF : (mag <<< 32) / V5;
        d = target - level;
        pm = longint'(d < 0 ? -d : d) * 64'd4294967;
        adj = longint'((pm + 64'h8000_0000) >> 32);
        n = level + (d < 0 ? -adj : adj);
        if (n < 0)
        begin
            n = 0;
        end
        if (n > 64'hFFFF_FFFF)
        begin
            n = 64'hFFFF_FFFF;
        end
        return n;
    endfunction

    function automatic mix_result_t predict_mix(logic signed [15:0] rs, logic signed [15:0] gs,
                                                logic signed [15:0] bs, logic [2:0] conn,
                                                logic [3:0] btn);
        mix_result_t res;
        longint ch [3];
        longint sum;
        longint mg;
        logic [3:0] edges;
        logic [2:0] active;
        logic [2:0] pass;
        ch[0] = conn[0] ? longint'(rs) : V5;
        ch[1] = conn[1] ? longint'(gs) : ch[0];
        ch[2] = conn[2] ? longint'(bs) : ch[1];
        for (int i = 0; i < 3; i++)
        begin
            ch[i] = soft_clip(scale_q14(ch[i], longint'(ch_gain[i])), V5);
        end
        edges = btn & ~prev_buttons;
        prev_buttons = btn;
        if (bank_sel)
        begin
            solo_flags[5:3] ^= edges[2:0];
        end
        else
        begin
            solo_flags[2:0] ^= edges[2:0];
        end
        if (edges[3])
        begin
            bank_sel = ~bank_sel;
        end
        for (int i = 0; i < 3; i++)
        begin
            led_acc[i] = smooth_led(led_acc[i], ch[i]);
            res.led[i] = led_acc[i][31:16];
        end
        active = bank_sel ? solo_flags[5:3] : solo_flags[2:0];
        pass = (active != 0) ? active : 3'b111;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (!pass[i])
            begin
                ch[i] = 0;
            end
            sum += ch[i];
            res.ch_out[i] = ch[i][15:0];
        end
        mg = longint'(signed'(mix_gain));
        res.bip = 16'(soft_clip(scale_q14(sum, mg), V10));
        res.uni = 16'(soft_clip(scale_q14(sum, mg < 0 ? -mg : mg), V10));
        res.pass = pass;
        res.solo = solo_flags;
        res.bank = bank_sel;
        return res;
    endfunction

    // Compare raw field bits, so signed fields are not sign extended on one side only.
    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v != act_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mix_result_t e;
        if (!rst_n)
        begin
            ch_gain = '{0, 0, 0};
            mix_gain = 0;
            solo_flags = 0;
            bank_sel = 0;
            prev_buttons = 0;
            led_acc = '{0, 0, 0};
            fail_count = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (tcsm_reg_t'(cfg.index))
                    REG_RED_GAIN:   ch_gain[0] = cfg.data[14:0];
                    REG_GREEN_GAIN: ch_gain[1] = cfg.data[14:0];
                    REG_BLUE_GAIN:  ch_gain[2] = cfg.data[14:0];
                    REG_MIX_GAIN:   mix_gain = cfg.data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result item, expected none actual %0h",
                             $time, out_ch.red_out);
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("red_out", e.ch_out[0], out_ch.red_out);
                    check_field("green_out", e.ch_out[1], out_ch.green_out);
                    check_field("blue_out", e.ch_out[2], out_ch.blue_out);
                    check_field("bipolar_mix", e.bip, out_ch.bipolar_mix);
                    check_field("unipolar_mix", e.uni, out_ch.unipolar_mix);
                    check_field("red_led", e.led[0], out_ch.red_led);
                    check_field("green_led", e.led[1], out_ch.green_led);
                    check_field("blue_led", e.led[2], out_ch.blue_led);
                    check_field("mix_pass_mask", 16'(e.pass), 16'(out_ch.mix_pass_mask));
                    check_field("solo_state", 16'(e.solo), 16'(out_ch.solo_state));
                    check_field("bank_out", 16'(e.bank), 16'(out_ch.bank_out));
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                expected_results.push_back(predict_mix(in_ch.red_sample, in_ch.green_sample,
                                                       in_ch.blue_sample, in_ch.connected_mask,
                                                       in_ch.button_levels));
            end
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Stimulus and verdict for the three channel solo mixer.
`timescale 1ns / 1ps
module testbench;
    import tcsm_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   recv_hold;

    tcsm_in_if  in_ch ();
    tcsm_out_if out_ch ();
    tcsm_cfg_if cfg ();

    three_channel_solo_mixer_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    tcsm_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg           (cfg),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off when asked.
    always @(posedge clk)
    begin
        if (recv_hold)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(tcsm_reg_t idx, logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        cfg.valid <= 1'b0;
    endtask

    task automatic set_gains(logic [14:0] r, logic [14:0] g, logic [14:0] b, logic [15:0] m);
        write_reg(REG_RED_GAIN, {1'b0, r});
        write_reg(REG_GREEN_GAIN, {1'b0, g});
        write_reg(REG_BLUE_GAIN, {1'b0, b});
        write_reg(REG_MIX_GAIN, m);
    endtask

    // Offer one item; idle gaps come before it, valid stays high between back to back items.
    task automatic send_mix_item(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                 logic [2:0] conn, logic [3:0] btn);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.red_sample <= r;
        in_ch.green_sample <= g;
        in_ch.blue_sample <= b;
        in_ch.connected_mask <= conn;
        in_ch.button_levels <= btn;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(6000)) - 3000);
            3: return 16'($signed($urandom_range(30000)) - 15000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [3:0] btn;
        btn = 0;
        for (int n = 0; n < count; n++)
        begin
            // Mostly hold buttons, press now and then to move the solo state.
            if ($urandom_range(3) == 0)
            begin
                btn = 4'($urandom);
            end
            send_mix_item(rand_sample(), rand_sample(), rand_sample(),
                          ($urandom_range(3) == 0) ? 3'($urandom) : 3'b111, btn);
        end
    endtask

    initial
    begin
        in_ch.valid = 0;
        in_ch.red_sample = 0;
        in_ch.green_sample = 0;
        in_ch.blue_sample = 0;
        in_ch.connected_mask = 0;
        in_ch.button_levels = 0;
        cfg.valid = 0;
        cfg.index = REG_RED_GAIN;
        cfg.data = 0;
        recv_hold = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, unconnected jacks, every button edge, both banks.
        set_gains(15'd16384, 15'd24576, 15'h7FFF, 16'h8000);
        send_mix_item(16'h7FFF, 16'h8000, 16'h0000, 3'b111, 4'b0000);
        send_mix_item(16'h8000, 16'h7FFF, 16'hFFFF, 3'b111, 4'b0001);
        send_mix_item(16'h1234, 16'h0000, 16'h0000, 3'b000, 4'b0000);
        send_mix_item(16'h2800, 16'h0000, 16'hD800, 3'b101, 4'b0010);
        send_mix_item(16'hC000, 16'h5000, 16'h0000, 3'b011, 4'b0110);
        send_mix_item(16'h2800, 16'h2801, 16'h27FF, 3'b111, 4'b1000);
        send_mix_item(16'h5000, 16'hB000, 16'h0001, 3'b111, 4'b0111);
        send_mix_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 3'b111, 4'b0000);
        send_mix_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 3'b111, 4'b1111);
        send_mix_item(16'h0400, 16'h0800, 16'hF000, 3'b111, 4'b0000);
        send_mix_item(16'h0400, 16'h0800, 16'hF000, 3'b111, 4'b1000);
        send_mix_item(16'h0000, 16'h0000, 16'h0000, 3'b110, 4'b0000);
        drain_results();
        set_gains(15'd0, 15'd0, 15'd0, 16'd0);
        send_mix_item(16'h7FFF, 16'h8000, 16'h1000, 3'b111, 4'b0100);
        send_mix_item(16'h7FFF, 16'h8000, 16'h1000, 3'b100, 4'b0000);
        drain_results();
        set_gains(15'd24576, 15'd24576, 15'd24576, 16'd24576);
        send_mix_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 3'b111, 4'b0000);
        send_mix_item(16'h8000, 16'h8000, 16'h8000, 3'b111, 4'b1000);

        send_idle_pct = 26;
        recv_idle_pct = 57;
        random_phase(250);
        drain_results();
        set_gains(15'($urandom_range(24576)), 15'($urandom_range(24576)),
                  15'($urandom_range(24576)), 16'(-24576));

        send_idle_pct = 57;
        recv_idle_pct = 26;
        random_phase(250);
        drain_results();
        set_gains(15'd8192, 15'd20000, 15'd12000, 16'sd12000);

        // Hold the receiver off long enough for the input to stall.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 1;
        fork
            begin
                repeat (400) @(posedge clk);
                recv_hold = 0;
            end
            random_phase(20);
        join
        random_phase(230);
        drain_results();

        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
